[design/md5_pkg.sv]
// MD5 package: round constants, rotate amounts, initial chaining values.
// No dependencies.
package md5_pkg;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  function automatic logic [31:0] round_const(input logic [5:0] r);
    logic [31:0] k [64];
    k = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return k[r];
  endfunction

  function automatic logic [4:0] rot_amount(input logic [3:0] i);
    logic [4:0] s [16];
    s = '{5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9, 5'd14, 5'd20,
          5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21};
    return s[i];
  endfunction

  // message word index for round r
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] lo;
    lo = r[3:0];
    case (r[5:4])
      2'd0: return lo;
      2'd1: return 4'((lo * 4'd5) + 4'd1);
      2'd2: return 4'((lo * 4'd3) + 4'd5);
      default: return 4'(lo * 4'd7);
    endcase
  endfunction

endpackage

[design/md5_ram.sv]
// Generic single-port write, one-port registered-read RAM.
// No dependencies.
module md5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[design/md5_round.sv]
// One MD5 round step: shared unit applied 64 times per block.
// Depends on md5_pkg.
module md5_round import md5_pkg::*; (
  input  logic [5:0]  r,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  input  logic [31:0] d,
  input  logic [31:0] m,
  output logic [31:0] b_new
);
  logic [31:0] f;
  logic [31:0] sum;
  logic [4:0]  s;
  logic [63:0] dbl;

  always_comb begin
    case (r[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (d & b) | (~d & c);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    sum = a + f + round_const(r) + m;
    s = rot_amount({r[5:4], r[1:0]});
    dbl = {sum, sum} << s;
    b_new = b + dbl[63:32];
  end
endmodule

[design/md5_stream_hasher.sv]
// Streaming MD5 top level: byte packer, word buffer, round sequencer.
// Depends on md5_pkg, md5_ram, md5_round.
//
// Each input word carries up to four message bytes (first byte in bits 7:0)
// and a last flag. Bytes are packed into 32-bit message words held in a
// 16-entry RAM. A full 64-byte block runs 64 rounds, one per cycle, through
// one shared round unit, plus a step to prime the RAM read and a step to fold
// the result into the chaining words. Bytes are taken one per cycle while no
// block is being compressed; once a non-final word's bytes are packed, the
// sequencer leaves the byte loop and returns to idle, where tready is high.
// A word that closes a block adds the compression (bytes straddling the block
// edge are finished after the block). A last word adds padding for one or two
// pad blocks, a compression per pad block, and four output words A, B, C, D.
// The block is not ready while a word is being worked on.
// After the digest the state reloads.
module md5_stream_hasher import md5_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // [31:0] data_word, [34:32] byte_count, rest 0
  input  logic        s_tlast,  // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,  // [31:0] digest_word, [33:32] word_index, rest 0
  output logic        m_tlast   // last_word
);
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_BYTES = 3'd1;
  localparam logic [2:0] ST_RUN   = 3'd2;
  localparam logic [2:0] ST_PAD   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]  state;
  logic [31:0] total;       // message byte count
  logic [31:0] hold_word;   // remaining input bytes, shifted down
  logic [2:0]  hold_cnt;
  logic        hold_last;
  logic [31:0] acc;         // partial message word being packed
  logic [31:0] h [4];
  logic [31:0] va, vb, vc, vd;
  logic [6:0]  rnd;         // 0: prime read, 1..64 rounds, 65 fold
  logic        pad_phase;   // 1 while filling a second pad block (no 0x80 byte)
  logic        pad_final;   // running block holds the length
  logic [3:0]  pad_idx;
  logic [1:0]  out_idx;

  // word RAM
  logic        we;
  logic [3:0]  waddr;
  logic [31:0] wdata;
  logic [3:0]  raddr;
  logic [31:0] rdata;

  md5_ram #(.WIDTH(32), .DEPTH(16)) u_buf (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  logic [31:0] b_new;
  md5_round u_round (
    .r(6'(rnd - 7'd1)), .a(va), .b(vb), .c(vc), .d(vd), .m(rdata), .b_new
  );

  // next round's message index; the registered read is issued in the cycle before that round
  assign raddr = msg_index(rnd[5:0]);

  logic [1:0]  pos;
  logic [7:0]  cur_byte;
  logic [31:0] acc_new;
  assign pos      = total[1:0];
  assign cur_byte = hold_word[7:0];
  always_comb begin
    acc_new = acc;
    case (pos)
      2'd0: acc_new = {24'd0, cur_byte};
      2'd1: acc_new[15:8]  = cur_byte;
      2'd2: acc_new[23:16] = cur_byte;
      default: acc_new[31:24] = cur_byte;
    endcase
  end

  // padding word for index pad_idx when message ends with total bytes
  logic [31:0] pad_word;
  logic [31:0] bitlen_lo;
  logic [31:0] bitlen_hi;
  logic [31:0] pad_mask;
  assign bitlen_lo = {total[28:0], 3'd0};
  assign bitlen_hi = {29'd0, total[31:29]};
  always_comb begin
    case (pos)
      2'd0: pad_mask = 32'h0000_0000;
      2'd1: pad_mask = 32'h0000_00ff;
      2'd2: pad_mask = 32'h0000_ffff;
      default: pad_mask = 32'h00ff_ffff;
    endcase
    pad_word = 32'd0;
    if (!pad_phase && pad_idx == total[5:2]) begin
      pad_word = (acc & pad_mask) | ({24'd0, PAD_BYTE} << {pos, 3'd0});
    end
    if (pad_final && pad_idx == 4'd14) pad_word = bitlen_lo;
    if (pad_final && pad_idx == 4'd15) pad_word = bitlen_hi;
  end

  always_comb begin
    we = 1'b0;
    waddr = total[5:2];
    wdata = acc_new;
    if (state == ST_BYTES && hold_cnt != 3'd0 && pos == 2'd3) we = 1'b1;
    if (state == ST_PAD) begin
      we = 1'b1;
      waddr = pad_idx;
      wdata = pad_word;
    end
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = {6'd0, out_idx, h[out_idx]};
  assign m_tlast  = (out_idx == 2'd3);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      total <= 32'd0;
      h[0] <= INIT_A; h[1] <= INIT_B; h[2] <= INIT_C; h[3] <= INIT_D;
      hold_cnt <= 3'd0;
      hold_last <= 1'b0;
      rnd <= 7'd0;
      pad_phase <= 1'b0;
      pad_final <= 1'b0;
      pad_idx <= 4'd0;
      out_idx <= 2'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            hold_word <= s_tdata[31:0];
            hold_cnt  <= (s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];
            hold_last <= s_tlast;
            state <= ST_BYTES;
          end
        end
        ST_BYTES: begin
          if (hold_cnt != 3'd0) begin
            acc <= acc_new;
            total <= total + 32'd1;
            hold_word <= {8'd0, hold_word[31:8]};
            hold_cnt <= hold_cnt - 3'd1;
            if (total[5:0] == 6'd63) begin
              rnd <= 7'd0;
              state <= ST_RUN;
            end
          end else if (hold_last) begin
            pad_phase <= 1'b0;
            pad_final <= (total[5:0] < 6'd56);
            pad_idx <= total[5:2];
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_PAD: begin
          pad_idx <= pad_idx + 4'd1;
          if (pad_idx == 4'd15) begin
            rnd <= 7'd0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          rnd <= rnd + 7'd1;
          if (rnd == 7'd0) begin
            va <= h[0]; vb <= h[1]; vc <= h[2]; vd <= h[3];
          end else if (rnd <= 7'd64) begin
            va <= vd; vd <= vc; vc <= vb; vb <= b_new;
          end else begin
            h[0] <= h[0] + va; h[1] <= h[1] + vb;
            h[2] <= h[2] + vc; h[3] <= h[3] + vd;
            // a data block always ends on a block edge; a first pad block never does
            if (hold_last && hold_cnt == 3'd0 && !pad_final && total[5:0] != 6'd0) begin
              // second block: zeros then length
              pad_phase <= 1'b1;
              pad_final <= 1'b1;
              pad_idx <= 4'd0;
              state <= ST_PAD;
            end else if (pad_final) begin
              out_idx <= 2'd0;
              state <= ST_OUT;
            end else begin
              state <= ST_BYTES;
            end
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            out_idx <= out_idx + 2'd1;
            if (out_idx == 2'd3) begin
              h[0] <= INIT_A; h[1] <= INIT_B; h[2] <= INIT_C; h[3] <= INIT_D;
              total <= 32'd0;
              hold_last <= 1'b0;
              pad_final <= 1'b0;
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

[design/md5_checker.sv]
// Port-level checker for md5_stream_hasher, bound to the top level.
// No package dependencies.
module md5_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);
  // never take input while a digest is pending
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid)) else $error("input ready during digest output");

  // tlast marks index three
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[33:32] == 2'd3)))
    else $error("tlast does not match word index");

  // index advances after each accepted non-final word
  a_seq: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=>
      (m_tvalid && m_tdata[33:32] == 2'($past(m_tdata[33:32]) + 2'd1)))
    else $error("digest words out of order");

  // stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("output changed while stalled");
endmodule

bind md5_stream_hasher md5_checker u_md5_checker (
  .clk, .rst, .s_tvalid, .s_tready, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);

[tb/tb.sv]
// Self-checking bench for md5_stream_hasher: random message streams with ready/valid idling.
// Depends on md5_pkg and md5_stream_hasher; its MD5 model lives here.
module tb;
  import md5_pkg::*;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  nbytes;
    logic        eom;
    logic        hold;  // wait for all digests before sending this word
  } in_word_t;

  typedef struct packed {
    logic [31:0] digest;
    logic [1:0]  index;
    logic        last;
  } digest_word_t;

  localparam int WATCHDOG = 4000;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tlast;

  md5_stream_hasher u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  in_word_t     pending_words[$];
  digest_word_t expected_digests[$];
  int           error_count = 0;
  int           idle_cycles = 0;
  bit           stimulus_done = 0;

  // model state
  logic [31:0] chain [4];
  logic [7:0]  blk [64];
  logic [31:0] byte_total;

  function automatic logic [31:0] rotl(logic [31:0] x, int s);
    return (s == 0) ? x : ((x << s) | (x >> (32 - s)));
  endfunction

  task automatic compress();
    logic [31:0] m [16];
    logic [31:0] a, b, c, d, f, t;
    int g;
    int k_idx;
    int ph;
    for (int r = 0; r < 16; r++)
      m[r] = {blk[4*r+3], blk[4*r+2], blk[4*r+1], blk[4*r]};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int r = 0; r < 64; r++) begin
      ph = r / 16;
      case (ph)
        0: begin f = (b & c) | (~b & d); g = r; end
        1: begin f = (d & b) | (~d & c); g = (5*r + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3*r + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7*r) % 16; end
      endcase
      k_idx = ph * 4 + r % 4;
      t = d; d = c; c = b;
      b = b + rotl(a + f + round_const(6'(r)) + m[g], int'(rot_amount(4'(k_idx))));
      a = t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endtask

  task automatic restart_digest();
    chain[0] = INIT_A; chain[1] = INIT_B; chain[2] = INIT_C; chain[3] = INIT_D;
    for (int i = 0; i < 64; i++) blk[i] = '0;
    byte_total = '0;
  endtask

  task automatic absorb_byte(logic [7:0] v);
    int pos;
    pos = byte_total[5:0];
    blk[pos] = v;
    byte_total++;
    if (pos == 63) compress();
  endtask

  // Predicts the digest words caused by one accepted input word.
  task automatic predict_digest(in_word_t w);
    int n;
    int left;
    logic [31:0] lo, hi;
    digest_word_t dw;
    n = (w.nbytes > 4) ? 4 : int'(w.nbytes);
    for (int i = 0; i < n; i++) absorb_byte(w.data[8*i +: 8]);
    if (!w.eom) return;
    left = byte_total[5:0];
    blk[left] = PAD_BYTE;
    left++;
    if (left > 56) begin
      for (int i = left; i < 64; i++) blk[i] = '0;
      compress();
      left = 0;
    end
    for (int i = left; i < 56; i++) blk[i] = '0;
    lo = byte_total << 3;
    hi = byte_total >> 29;
    for (int i = 0; i < 4; i++) begin
      blk[56+i] = lo[8*i +: 8];
      blk[60+i] = hi[8*i +: 8];
    end
    compress();
    for (int i = 0; i < 4; i++) begin
      dw.digest = chain[i];
      dw.index = 2'(i);
      dw.last = (i == 3);
      expected_digests.push_back(dw);
    end
    restart_digest();
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  function automatic in_word_t mk(logic [31:0] d, int n, bit e, bit h = 0);
    in_word_t w;
    w.data = d; w.nbytes = 3'(n); w.eom = e; w.hold = h;
    return w;
  endfunction

  // a message of len bytes in words of random size; sometimes garbage counts 5..7
  task automatic queue_message(int len, bit hold_first);
    int n;
    bit first;
    first = 1;
    while (len > 0) begin
      n = $urandom_range(1, 4);
      if (n > len) n = len;
      len -= n;
      if (n == 4 && $urandom_range(0, 5) == 0) n = $urandom_range(5, 7);
      pending_words.push_back(mk($urandom, n, len == 0 && $urandom_range(0, 3) != 0,
                                 hold_first && first));
      first = 0;
      if ($urandom_range(0, 9) == 0) pending_words.push_back(mk($urandom, 0, 0));
    end
    if (pending_words[$].eom == 0) pending_words.push_back(mk($urandom, 0, 1));
  endtask

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    rst = 1;
    repeat (7) @(posedge clk);
    rst <= 0;
  end

  initial begin
    // directed: empty message, extremes, counts 0..7, block-edge lengths
    pending_words.push_back(mk(32'h0, 0, 1));
    pending_words.push_back(mk(32'hffffffff, 4, 1));
    pending_words.push_back(mk(32'h00000000, 4, 0));
    pending_words.push_back(mk(32'h00000061, 1, 1));
    pending_words.push_back(mk(32'h00636261, 3, 1));
    pending_words.push_back(mk(32'h12345678, 2, 0));
    pending_words.push_back(mk(32'h9abcdef0, 7, 0));
    pending_words.push_back(mk(32'h55aa55aa, 5, 0));
    pending_words.push_back(mk(32'hdeadbeef, 6, 0, 1));
    pending_words.push_back(mk(32'hcafef00d, 0, 0));
    pending_words.push_back(mk(32'h0badf00d, 4, 1));
    for (int i = 0; i < 14; i++) pending_words.push_back(mk($urandom, 4, i == 13));  // 56 bytes
    // random messages, mostly short, a few multi-block
    while (pending_words.size() < 440) begin
      case ($urandom_range(0, 9))
        0: queue_message($urandom_range(55, 130), $urandom_range(0, 3) == 0);
        1: queue_message($urandom_range(60, 68), 0);
        default: queue_message($urandom_range(1, 20), $urandom_range(0, 5) == 0);
      endcase
    end
    stimulus_done = 1;
  end

  // driver
  int send_gap = 0;
  in_word_t cur_word;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
      s_tdata <= '0;
      s_tlast <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_digest(cur_word);
        send_gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          s_tvalid <= 0;
        end else if (pending_words.size() > 0 &&
                     !(pending_words[0].hold && expected_digests.size() > 0)) begin
          cur_word = pending_words.pop_front();
          s_tvalid <= 1;
          s_tdata <= {5'b0, cur_word.nbytes, cur_word.data};
          s_tlast <= cur_word.eom;
        end else begin
          s_tvalid <= 0;
        end
      end
    end
  end

  // monitor, receiver stalls and watchdog
  int stall = 0;
  digest_word_t want;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_digests.size() == 0) begin
          report_mismatch("unexpected word", m_tdata[31:0], '0);
        end else begin
          want = expected_digests.pop_front();
          if (m_tdata[31:0] !== want.digest) report_mismatch("digest", m_tdata[31:0], want.digest);
          if (m_tdata[33:32] !== want.index) report_mismatch("index", m_tdata[33:32], want.index);
          if (m_tdata[39:34] !== '0) report_mismatch("pad bits", m_tdata[39:34], '0);
          if (m_tlast !== want.last) report_mismatch("last", m_tlast, want.last);
        end
        stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
      end
      if (stall > 0) begin
        stall--;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin
    restart_digest();
    @(negedge rst);
    fork
      wait (stimulus_done && pending_words.size() == 0 && !s_tvalid &&
            expected_digests.size() == 0);
      wait (idle_cycles >= WATCHDOG);
    join_any
    if (idle_cycles >= WATCHDOG) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      repeat (200) @(posedge clk);
      if (error_count == 0 && expected_digests.size() == 0) begin
        $display("CHECK OK");
      end else begin
        $display("CHECK FAILED");
      end
      $finish;
    end
  end

endmodule
